### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define PRT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

### rtl/prt_pkg.sv
// Types, constants and helpers of the periodic release tracker.
package prt_pkg;

    localparam int unsigned PRT_NUM_TASKS = 8;
    localparam logic [31:0] PRT_FREQ_RESET = 32'd62500000;
    localparam logic [19:0] PRT_US_PER_S = 20'd1000000;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_DONE   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [31:0] CNT32_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CVT_PER, ST_CVT_DL, ST_LAUNCH, ST_RUN, ST_PUSH
    } ctl_state_t;

    typedef enum logic [1:0] {
        CV_IDLE, CV_MUL, CV_DIV, CV_REM
    } cvt_state_t;

    // Transaction record walking down the slot chain.
    typedef struct packed {
        logic        vld;
        logic [1:0]  mode;
        logic [2:0]  slot;
        logic [63:0] now;
        logic [63:0] per;
        logic [63:0] dl;
        logic [63:0] earliest;
        logic        found;
        logic [7:0]  mask;
        logic [31:0] act;
        logic [63:0] worst;
        logic [63:0] last;
        logic [31:0] miss;
    } tok_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == CNT32_MAX) ? v : v + 32'd1;
    endfunction

endpackage

### rtl/prt_cvt.sv
// Microsecond to cycle converter: 32x32 multiply, then divide by 1e6 in 16-bit digits.
module prt_cvt
    import prt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] us,
    input  logic [31:0] freq,
    output logic        done,
    output logic [63:0] cycles
);

    // 1e6 = 64 * 15625: drop six bits, then divide by 15625 one 16-bit digit at a time
    localparam logic [13:0] DivLo = 14'd15625;
    // ceil(2^44 / 15625): exact for every partial dividend below 15625 * 2^16
    localparam logic [30:0] Recip = 31'd1125899907;

    cvt_state_t  state_reg, state_next;
    logic [31:0] us_reg, us_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [13:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [63:0] prod;
    logic [29:0] part;
    logic [60:0] part_m;
    logic [29:0] q_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        us_reg  <= us_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign prod   = 64'(us_reg) * 64'(freq);
    // partial dividend: running remainder with the next dividend digit's bits
    assign part   = {rem_reg, dvd_reg[63:48]};
    assign part_m = 61'(part) * 61'(Recip);
    assign q_d    = 30'(q_reg) * 30'(DivLo);

    always_comb begin
        state_next = state_reg;
        us_next    = us_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        case (state_reg)
            CV_IDLE: ;
            CV_MUL: begin
                dvd_next   = {6'd0, prod[63:6]};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = CV_DIV;
            end
            CV_DIV: begin
                q_next     = part_m[59:44];
                state_next = CV_REM;
            end
            CV_REM: begin
                rem_next = 14'(part - q_d);
                dvd_next = {dvd_reg[47:0], q_reg};
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    done       = 1'b1;
                    state_next = CV_IDLE;
                end else begin
                    state_next = CV_DIV;
                end
            end
            default: state_next = CV_IDLE;
        endcase
        if (start) begin
            us_next    = us;
            state_next = CV_MUL;
        end
    end

    assign cycles = dvd_next;

endmodule

### rtl/prt_cell.sv
// One task slot: holds its state and updates it as the transaction passes.
module prt_cell
    import prt_pkg::*;
#(
    parameter int Idx = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  tok_t tok_in,
    output tok_t tok_out
);

    localparam logic [2:0] MaskBit = 3'(Idx);

    logic [63:0] per_reg, per_next, dl_reg, dl_next, rel_reg, rel_next;
    logic [63:0] nrt_reg, nrt_next, worst_reg, worst_next, last_reg, last_next;
    logic [31:0] act_reg, act_next, miss_reg, miss_next;
    logic        sleep_reg, sleep_next;
    tok_t        tok_reg, tok_next;

    logic        mine, active, due;
    logic [63:0] resp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_reg   <= '0;
            dl_reg    <= '0;
            rel_reg   <= '0;
            nrt_reg   <= '0;
            worst_reg <= '0;
            last_reg  <= '0;
            act_reg   <= '0;
            miss_reg  <= '0;
            sleep_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            per_reg   <= per_next;
            dl_reg    <= dl_next;
            rel_reg   <= rel_next;
            nrt_reg   <= nrt_next;
            worst_reg <= worst_next;
            last_reg  <= last_next;
            act_reg   <= act_next;
            miss_reg  <= miss_next;
            sleep_reg <= sleep_next;
            tok_reg   <= tok_next;
        end
    end

    assign mine   = (int'(tok_in.slot) == Idx);
    assign active = (per_reg != 64'd0);
    assign due    = (tok_in.now >= nrt_reg);
    assign resp   = tok_in.now - rel_reg;

    always_comb begin
        per_next   = per_reg;
        dl_next    = dl_reg;
        rel_next   = rel_reg;
        nrt_next   = nrt_reg;
        worst_next = worst_reg;
        last_next  = last_reg;
        act_next   = act_reg;
        miss_next  = miss_reg;
        sleep_next = sleep_reg;
        tok_next   = tok_in;
        if (tok_in.vld) begin
            case (tok_in.mode)
                MODE_CREATE: begin
                    if (mine) begin
                        per_next   = tok_in.per;
                        dl_next    = tok_in.dl;
                        rel_next   = tok_in.now;
                        nrt_next   = tok_in.now + tok_in.per;
                        act_next   = 32'd1;
                        sleep_next = 1'b0;
                        worst_next = '0;
                        last_next  = '0;
                        miss_next  = '0;
                    end
                end
                MODE_DONE: begin
                    if (mine && active) begin
                        last_next = resp;
                        if (act_reg > 32'd1) begin
                            if (resp > worst_reg) worst_next = resp;
                            if (resp > dl_reg) miss_next = sat_inc32(miss_reg);
                        end
                        sleep_next = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (active) begin
                        if (due) begin
                            if (sleep_reg) begin
                                rel_next   = nrt_reg;
                                sleep_next = 1'b0;
                                act_next   = sat_inc32(act_reg);
                                if (Idx < 8) tok_next.mask[MaskBit] = 1'b1;
                            end else begin
                                miss_next = sat_inc32(miss_reg);
                            end
                            nrt_next = nrt_reg + per_reg;
                        end
                        if (!tok_in.found || nrt_next < tok_in.earliest) begin
                            tok_next.earliest = nrt_next;
                            tok_next.found    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (mine && (tok_in.mode == MODE_CREATE || tok_in.mode == MODE_DONE)) begin
                tok_next.act   = act_next;
                tok_next.worst = worst_next;
                tok_next.last  = last_next;
                tok_next.miss  = miss_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/periodic_release_tracker_top.sv
// Top level of the periodic release tracker: control, converter and slot chain.
// Flow: a create converts its period to cycles, then its deadline when dl_us is nonzero;
// every transaction is then launched into the slot chain, registered by each cell in turn,
// caught in the result skid and moved to the output register. A new transaction is taken only
// after the last one is pushed; a result still waiting for m_tready holds off the next push.
// Reset (aresetn low, synchronous): slots inactive, statistics zero, frequency 62500000 Hz.
module periodic_release_tracker_top
    import prt_pkg::*;
#(
    parameter int NUM_TASKS = PRT_NUM_TASKS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: clock_freq_hz
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: slot[2:0], now[66:3], per_us[98:67], dl_us[130:99], zero pad
    input  logic [135:0] s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: earliest_release[63:0], released_mask[71:64],
    // activation_count[103:72], worst_response[167:104],
    // last_response[231:168], miss_count[263:232]
    output logic [263:0] m_tdata
);

    `include "assert_macros.svh"

    ctl_state_t  state_reg, state_next;
    logic [31:0] freq_reg;

    // captured transaction
    logic [1:0]  mode_reg;
    logic [2:0]  slot_reg;
    logic [63:0] now_reg;
    logic [31:0] dl_us_reg;
    logic [63:0] per_cyc_reg, per_cyc_next, dl_cyc_reg, dl_cyc_next;

    // result skid and output register
    tok_t          res_reg, res_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [263:0]  m_tdata_reg, m_tdata_next;

    // converter
    logic        cvt_start, cvt_done;
    logic [31:0] cvt_us;
    logic [63:0] cvt_q;

    // slot chain
    tok_t                 tok_head;
    tok_t                 tok [NUM_TASKS+1];
    logic [NUM_TASKS:0]   tok_vld;
    logic                 accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            freq_reg     <= PRT_FREQ_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) freq_reg <= cfg_wr_data;
        end
        if (accept) begin
            mode_reg   <= s_tuser;
            slot_reg   <= s_tdata[2:0];
            now_reg    <= s_tdata[66:3];
            dl_us_reg  <= s_tdata[130:99];
        end
        per_cyc_reg <= per_cyc_next;
        dl_cyc_reg  <= dl_cyc_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        per_cyc_next  = per_cyc_reg;
        dl_cyc_next   = dl_cyc_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;
        cvt_start     = 1'b0;
        cvt_us        = s_tdata[98:67];
        tok_head      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == MODE_CREATE) begin
                        cvt_start  = 1'b1;
                        state_next = ST_CVT_PER;
                    end else begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_CVT_PER: begin
                if (cvt_done) begin
                    per_cyc_next = cvt_q;
                    if (dl_us_reg != 32'd0) begin
                        cvt_start  = 1'b1;
                        cvt_us     = dl_us_reg;
                        state_next = ST_CVT_DL;
                    end else begin
                        dl_cyc_next = cvt_q;  // deadline follows the period
                        state_next  = ST_LAUNCH;
                    end
                end
            end
            ST_CVT_DL: begin
                if (cvt_done) begin
                    dl_cyc_next = cvt_q;
                    state_next  = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                tok_head.vld  = 1'b1;
                tok_head.mode = mode_reg;
                tok_head.slot = slot_reg;
                tok_head.now  = now_reg;
                tok_head.per  = per_cyc_reg;
                tok_head.dl   = dl_cyc_reg;
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                if (tok[NUM_TASKS].vld) begin
                    res_next   = tok[NUM_TASKS];
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    // only a tick reports a release; stats come back zero on a tick
                    m_tdata_next  = {res_reg.miss, res_reg.last, res_reg.worst,
                                     res_reg.act, res_reg.mask, res_reg.earliest};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    prt_cvt u_cvt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cvt_start),
        .us      (cvt_us),
        .freq    (freq_reg),
        .done    (cvt_done),
        .cycles  (cvt_q)
    );

    assign tok[0] = tok_head;

    // each cell registers the transaction and hands it to its neighbor
    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
        prt_cell #(.Idx(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    for (genvar v = 0; v <= NUM_TASKS; v++) begin : g_vld
        assign tok_vld[v] = tok[v].vld;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // at most one transaction in the chain
    `PRT_ASSERT(a_one_tok, aclk, aresetn, $countones(tok_vld) <= 1)
    // input is only taken with the chain empty
    `PRT_ASSERT(a_idle_empty, aclk, aresetn, s_tready |-> (tok_vld == '0))
    // converter finishes only while control waits for it
    `PRT_ASSERT(a_cvt_done, aclk, aresetn,
        cvt_done |-> (state_reg == ST_CVT_PER || state_reg == ST_CVT_DL))
    // the chain end fires only while control waits for it
    `PRT_NEVER(a_end_run, aclk, aresetn, tok_vld[NUM_TASKS] && state_reg != ST_RUN)

endmodule
